>>> rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// shared constants, types and the arctangent table of the sphere generator
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int MAX_BANDS_DEF   = 255;
  localparam int ANGLE_ITER_DEF  = 16;
  localparam int ATAN_LEN        = 24;

  localparam int DIV_W   = 40;
  localparam int DEN_W   = 9;
  localparam int CORD_W  = 33;
  localparam int NLANE   = 4;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] GAIN_Q30    = 32'd652032874;
  localparam logic [31:0] ONE_Q30     = 32'd1073741824;

  typedef enum logic [1:0] {
    REG_STACK_COUNT = 2'd0,
    REG_SLICE_COUNT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic        in_range;
    logic        has_quad;
    logic [15:0] tl;
    logic [15:0] bl;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [1:0]  quad_p;
    logic [1:0]  quad_t;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } ext_t;

  function automatic logic [31:0] atan_q30(input int k);
    logic [31:0] a;
    case (k)
      0:  a = 32'd843314856;
      1:  a = 32'd497837829;
      2:  a = 32'd263043836;
      3:  a = 32'd133525158;
      4:  a = 32'd67021686;
      5:  a = 32'd33543515;
      6:  a = 32'd16775850;
      7:  a = 32'd8388437;
      8:  a = 32'd4194282;
      9:  a = 32'd2097149;
      10: a = 32'd1048575;
      11: a = 32'd524287;
      12: a = 32'd262143;
      13: a = 32'd131071;
      14: a = 32'd65535;
      15: a = 32'd32767;
      16: a = 32'd16383;
      17: a = 32'd8191;
      18: a = 32'd4095;
      19: a = 32'd2047;
      20: a = 32'd1023;
      21: a = 32'd511;
      22: a = 32'd255;
      23: a = 32'd127;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/uvs_div_cell.sv
// ----------------------------------------------------------------------------
// uvs_div_cell
// one restoring division step, registered, handing its word to the next cell
// ----------------------------------------------------------------------------
module uvs_div_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [uvs_pkg::DIV_W-1:0]   dq_i,
  input  logic [uvs_pkg::DEN_W-1:0]   rem_i,
  input  logic [uvs_pkg::DEN_W-1:0]   den_i,
  output logic [uvs_pkg::DIV_W-1:0]   dq_o,
  output logic [uvs_pkg::DEN_W-1:0]   rem_o,
  output logic [uvs_pkg::DEN_W-1:0]   den_o
);

  logic [uvs_pkg::DEN_W:0]   trial;
  logic [uvs_pkg::DEN_W:0]   diff;
  logic                      qbit;
  logic [uvs_pkg::DEN_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_i, dq_i[uvs_pkg::DIV_W-1]};
    diff    = trial - {1'b0, den_i};
    qbit    = (trial >= {1'b0, den_i});
    rem_nxt = qbit ? diff[uvs_pkg::DEN_W-1:0] : trial[uvs_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dq_o  <= {dq_i[uvs_pkg::DIV_W-2:0], qbit};
      rem_o <= rem_nxt;
      den_o <= den_i;
    end
  end

endmodule

>>> rtl/uvs_cordic_cell.sv
// ----------------------------------------------------------------------------
// uvs_cordic_cell
// one rotation-mode cordic step, registered
// ----------------------------------------------------------------------------
module uvs_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [uvs_pkg::CORD_W-1:0] x_i,
  input  logic signed [uvs_pkg::CORD_W-1:0] y_i,
  input  logic signed [uvs_pkg::CORD_W-1:0] z_i,
  output logic signed [uvs_pkg::CORD_W-1:0] x_o,
  output logic signed [uvs_pkg::CORD_W-1:0] y_o,
  output logic signed [uvs_pkg::CORD_W-1:0] z_o
);

  localparam logic signed [uvs_pkg::CORD_W-1:0] ATAN =
    {1'b0, uvs_pkg::atan_q30(STEP)};

  logic signed [uvs_pkg::CORD_W-1:0] xs, ys;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_i[uvs_pkg::CORD_W-1]) begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - ATAN;
      end else begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + ATAN;
      end
    end
  end

endmodule

>>> rtl/indexed_uv_sphere_vertex_generator_top.sv
// ----------------------------------------------------------------------------
// indexed_uv_sphere_vertex_generator_top
// uv sphere vertex, texture coordinate and quad index generator
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | in        | in_valid in_ready in_row in_column
// out     | out       | out_valid out_ready out_in_range .. out_bottom_right
// cfg     | in        | cfg_valid cfg_ready cfg_index cfg_data
//
// one request per cycle unless a held result stalls; 40 divider cells, an angle
// register, min(ANGLE_ITERATIONS,24) cordic cells, map, product, output registers
// synchronous reset clears valids and sets 16 stacks, 32 slices
// a held result stalls the whole chain; in_ready drops only then
// ----------------------------------------------------------------------------
module indexed_uv_sphere_vertex_generator_top #(
  parameter int MAX_BANDS        = uvs_pkg::MAX_BANDS_DEF,
  parameter int ANGLE_ITERATIONS = uvs_pkg::ANGLE_ITER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_row,
  input  logic [7:0]  in_column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_in_range,
  output logic [15:0] out_pos_x,
  output logic [15:0] out_pos_y,
  output logic [15:0] out_pos_z,
  output logic [16:0] out_tex_u,
  output logic [16:0] out_tex_v,
  output logic        out_has_quad,
  output logic [15:0] out_top_left,
  output logic [15:0] out_top_right,
  output logic [15:0] out_bottom_left,
  output logic [15:0] out_bottom_right,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int NSTEP = (ANGLE_ITERATIONS < uvs_pkg::ATAN_LEN) ?
                         ANGLE_ITERATIONS : uvs_pkg::ATAN_LEN;
  localparam int DSTEP = uvs_pkg::DIV_W;
  localparam int DW    = uvs_pkg::DIV_W;
  localparam int NW    = uvs_pkg::DEN_W;
  localparam int CW    = uvs_pkg::CORD_W;
  localparam logic [7:0] MAXB = 8'(MAX_BANDS);

  logic       en;
  logic [7:0] stk_r, slc_r;

  // config
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stk_r <= 8'd16;
      slc_r <= 8'd32;
    end else if (cfg_valid) begin
      case (uvs_pkg::cfg_reg_t'(cfg_index))
        uvs_pkg::REG_STACK_COUNT: stk_r <= cfg_data;
        uvs_pkg::REG_SLICE_COUNT: slc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // entry logic
  logic [7:0]    stacks, slices, s0, s1;
  logic [8:0]    slc_p1;
  logic [16:0]   tl_full;
  uvs_pkg::side_t side_in;
  logic [DW-1:0] dvd_w [uvs_pkg::NLANE];
  logic [NW-1:0] den_w [uvs_pkg::NLANE];

  always_comb begin
    s0      = (stk_r == 8'd0) ? 8'd1 : stk_r;
    s1      = (slc_r == 8'd0) ? 8'd1 : slc_r;
    stacks  = (s0 > MAXB) ? MAXB : s0;
    slices  = (s1 > MAXB) ? MAXB : s1;
    slc_p1  = {1'b0, slices} + 9'd1;
    tl_full = 17'(in_row) * 17'(slc_p1) + 17'(in_column);
    side_in.in_range = (in_row <= stacks) && (in_column <= slices);
    side_in.has_quad = (in_row < stacks) && (in_column < slices);
    side_in.tl       = tl_full[15:0];
    side_in.bl       = tl_full[15:0] + {7'd0, slc_p1};
    dvd_w[0] = {in_row, 24'd0, stacks};
    den_w[0] = {stacks, 1'b0};
    dvd_w[1] = {in_column, 25'd0, slices[7:1]};
    den_w[1] = {1'b0, slices};
    dvd_w[2] = {16'd0, in_column, 9'd0, slices[7:1]};
    den_w[2] = {1'b0, slices};
    dvd_w[3] = {16'd0, in_row, 9'd0, stacks[7:1]};
    den_w[3] = {1'b0, stacks};
  end

  // divider chains
  logic [DW-1:0] dq_w  [uvs_pkg::NLANE][DSTEP+1];
  logic [NW-1:0] rem_w [uvs_pkg::NLANE][DSTEP+1];
  logic [NW-1:0] dn_w  [uvs_pkg::NLANE][DSTEP+1];

  for (genvar l = 0; l < uvs_pkg::NLANE; l++) begin : g_lane
    assign dq_w[l][0]  = dvd_w[l];
    assign rem_w[l][0] = '0;
    assign dn_w[l][0]  = den_w[l];
    for (genvar s = 0; s < DSTEP; s++) begin : g_div
      uvs_div_cell u_cell (
        .clk   (clk),
        .en    (en),
        .dq_i  (dq_w[l][s]),
        .rem_i (rem_w[l][s]),
        .den_i (dn_w[l][s]),
        .dq_o  (dq_w[l][s+1]),
        .rem_o (rem_w[l][s+1]),
        .den_o (dn_w[l][s+1])
      );
    end
  end

  uvs_pkg::side_t side_r [DSTEP];
  logic [DSTEP-1:0] vd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= '0;
    end else if (en) begin
      vd_r <= {vd_r[DSTEP-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int k = 1; k < DSTEP; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // angle stage
  logic [31:0]          ph_p, ph_t;
  logic [60:0]          zp_p, zp_t;
  logic signed [CW-1:0] zp_r, zt_r;
  uvs_pkg::ext_t        ext_z_r;
  logic                 vz_r;

  always_comb begin
    ph_p = dq_w[0][DSTEP][31:0];
    ph_t = dq_w[1][DSTEP][31:0];
    zp_p = {31'd0, ph_p[29:0]} * {30'd0, uvs_pkg::HALF_PI_Q30} + 61'h20000000;
    zp_t = {31'd0, ph_t[29:0]} * {30'd0, uvs_pkg::HALF_PI_Q30} + 61'h20000000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vz_r <= 1'b0;
    end else if (en) begin
      vz_r <= vd_r[DSTEP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zp_r           <= {2'b00, zp_p[60:30]};
      zt_r           <= {2'b00, zp_t[60:30]};
      ext_z_r.side   <= side_r[DSTEP-1];
      ext_z_r.quad_p <= ph_p[31:30];
      ext_z_r.quad_t <= ph_t[31:30];
      ext_z_r.tex_u  <= dq_w[2][DSTEP][16:0];
      ext_z_r.tex_v  <= dq_w[3][DSTEP][16:0];
    end
  end

  // cordic chains
  logic signed [CW-1:0] cx_w [2][NSTEP+1];
  logic signed [CW-1:0] cy_w [2][NSTEP+1];
  logic signed [CW-1:0] cz_w [2][NSTEP+1];

  assign cz_w[0][0] = zp_r;
  assign cz_w[1][0] = zt_r;

  for (genvar a = 0; a < 2; a++) begin : g_ang
    assign cx_w[a][0] = {1'b0, uvs_pkg::GAIN_Q30};
    assign cy_w[a][0] = '0;
    for (genvar s = 0; s < NSTEP; s++) begin : g_cord
      uvs_cordic_cell #(.STEP(s)) u_cell (
        .clk (clk),
        .en  (en),
        .x_i (cx_w[a][s]),
        .y_i (cy_w[a][s]),
        .z_i (cz_w[a][s]),
        .x_o (cx_w[a][s+1]),
        .y_o (cy_w[a][s+1]),
        .z_o (cz_w[a][s+1])
      );
    end
  end

  uvs_pkg::ext_t ext_c_r [NSTEP];
  logic [NSTEP-1:0] vc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= '0;
    end else if (en) begin
      vc_r <= {vc_r[NSTEP-2:0], vz_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ext_c_r[0] <= ext_z_r;
      for (int k = 1; k < NSTEP; k++) begin
        ext_c_r[k] <= ext_c_r[k-1];
      end
    end
  end

  // clamp and quadrant map
  localparam logic signed [CW-1:0] POS1 = {1'b0, uvs_pkg::ONE_Q30};
  localparam logic signed [CW-1:0] NEG1 = -POS1;

  logic signed [CW-1:0] xc [2];
  logic signed [CW-1:0] yc [2];
  logic signed [CW-1:0] sn [2];
  logic signed [CW-1:0] cs [2];
  logic [1:0]           qd [2];

  always_comb begin
    qd[0] = ext_c_r[NSTEP-1].quad_p;
    qd[1] = ext_c_r[NSTEP-1].quad_t;
    for (int a = 0; a < 2; a++) begin
      xc[a] = (cx_w[a][NSTEP] < NEG1) ? NEG1 : ((cx_w[a][NSTEP] > POS1) ? POS1 : cx_w[a][NSTEP]);
      yc[a] = (cy_w[a][NSTEP] < NEG1) ? NEG1 : ((cy_w[a][NSTEP] > POS1) ? POS1 : cy_w[a][NSTEP]);
      case (qd[a])
        2'd0:    begin cs[a] = xc[a];  sn[a] = yc[a];  end
        2'd1:    begin cs[a] = -yc[a]; sn[a] = xc[a];  end
        2'd2:    begin cs[a] = -xc[a]; sn[a] = -yc[a]; end
        default: begin cs[a] = yc[a];  sn[a] = -xc[a]; end
      endcase
    end
  end

  logic signed [31:0] sp_r, cp_r, st_r, ct_r;
  uvs_pkg::ext_t      ext_m_r;
  logic               vm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= vc_r[NSTEP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp_r    <= sn[0][31:0];
      cp_r    <= cs[0][31:0];
      st_r    <= sn[1][31:0];
      ct_r    <= cs[1][31:0];
      ext_m_r <= ext_c_r[NSTEP-1];
    end
  end

  // products
  logic signed [63:0] px_r, pz_r;
  logic signed [31:0] py_r;
  uvs_pkg::ext_t      ext_p_r;
  logic               vp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (en) begin
      vp_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r    <= sp_r * ct_r;
      pz_r    <= sp_r * st_r;
      py_r    <= cp_r;
      ext_p_r <= ext_m_r;
    end
  end

  // round to q1.14 and output register
  function automatic logic [15:0] q14(input logic signed [63:0] v, input int sh);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r > 64'sd16384) begin
      r = 64'sd16384;
    end else if (r < -64'sd16384) begin
      r = -64'sd16384;
    end
    return r[15:0];
  endfunction

  logic        ok, qd_ok;
  logic        out_valid_r;

  assign ok    = ext_p_r.side.in_range;
  assign qd_ok = ok && ext_p_r.side.has_quad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_in_range     <= ok;
      out_pos_x        <= ok ? q14(px_r, 46) : 16'd0;
      out_pos_y        <= ok ? q14(64'(py_r), 16) : 16'd0;
      out_pos_z        <= ok ? q14(pz_r, 46) : 16'd0;
      out_tex_u        <= ok ? ext_p_r.tex_u : 17'd0;
      out_tex_v        <= ok ? ext_p_r.tex_v : 17'd0;
      out_has_quad     <= qd_ok;
      out_top_left     <= qd_ok ? ext_p_r.side.tl : 16'd0;
      out_top_right    <= qd_ok ? ext_p_r.side.tl + 16'd1 : 16'd0;
      out_bottom_left  <= qd_ok ? ext_p_r.side.bl : 16'd0;
      out_bottom_right <= qd_ok ? ext_p_r.side.bl + 16'd1 : 16'd0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> verif/uvs_vertex_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uvs_vertex_checker
// tracks band counts, predicts each vertex and compares results in order
// ----------------------------------------------------------------------------
module uvs_vertex_checker #(
  parameter int MAX_BANDS        = uvs_pkg::MAX_BANDS_DEF,
  parameter int ANGLE_ITERATIONS = uvs_pkg::ANGLE_ITER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_row,
  input  logic [7:0]  in_column,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_in_range,
  input  logic [15:0] out_pos_x,
  input  logic [15:0] out_pos_y,
  input  logic [15:0] out_pos_z,
  input  logic [16:0] out_tex_u,
  input  logic [16:0] out_tex_v,
  input  logic        out_has_quad,
  input  logic [15:0] out_top_left,
  input  logic [15:0] out_top_right,
  input  logic [15:0] out_bottom_left,
  input  logic [15:0] out_bottom_right,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          vertices_pending
);

  typedef struct packed {
    logic        in_range;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic        has_quad;
    logic [15:0] top_left;
    logic [15:0] top_right;
    logic [15:0] bottom_left;
    logic [15:0] bottom_right;
  } vertex_t;

  localparam longint ONE_FX  = 64'sd1073741824;
  localparam longint GAIN_FX = 64'sd652032874;
  localparam longint unsigned HALF_PI_FX = 64'd1686629713;
  localparam int STEPS = (ANGLE_ITERATIONS < 24) ? ANGLE_ITERATIONS : 24;

  localparam longint ARCTAN [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  logic [7:0] stack_reg;
  logic [7:0] slice_reg;
  vertex_t    vertex_q[$];

  function automatic longint unsigned bands(input logic [7:0] r);
    longint unsigned v;
    v = r;
    if (v == 0) v = 1;
    if (v > MAX_BANDS) v = MAX_BANDS;
    return v;
  endfunction

  function automatic longint clip(input longint v, input longint lim);
    return (v < -lim) ? -lim : ((v > lim) ? lim : v);
  endfunction

  function automatic void angle_sin_cos(input longint unsigned num,
                                        input longint unsigned den,
                                        output longint s, output longint c);
    longint unsigned phase;
    longint unsigned rem;
    logic [1:0]      quad;
    longint          x, y, z, nx, ny;
    phase = (((num << 32) + den / 2) / den) & 64'hFFFF_FFFF;
    quad  = phase[31:30];
    rem   = phase & 64'h3FFF_FFFF;
    z     = longint'((rem * HALF_PI_FX + (64'd1 << 29)) >> 30);
    x     = GAIN_FX;
    y     = 0;
    for (int k = 0; k < STEPS; k++) begin
      if (z >= 0) begin
        nx = x - (y >>> k);
        ny = y + (x >>> k);
        z  = z - ARCTAN[k];
      end else begin
        nx = x + (y >>> k);
        ny = y - (x >>> k);
        z  = z + ARCTAN[k];
      end
      x = nx;
      y = ny;
    end
    x = clip(x, ONE_FX);
    y = clip(y, ONE_FX);
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [15:0] round_q14(input longint v, input int sh);
    longint r;
    r = (v + (longint'(1) << (sh - 1))) >>> sh;
    r = clip(r, 16384);
    return r[15:0];
  endfunction

  function automatic vertex_t predict_vertex(input logic [7:0] row,
                                             input logic [7:0] column);
    vertex_t         v;
    longint unsigned st, sl, i, j, tl, bl, tu, tv;
    longint          sp, cp, sth, cth;
    v  = '0;
    st = bands(stack_reg);
    sl = bands(slice_reg);
    i  = row;
    j  = column;
    if (i > st || j > sl) return v;
    angle_sin_cos(i, 2 * st, sp, cp);
    angle_sin_cos(j, sl, sth, cth);
    tu = (j * 65536 + sl / 2) / sl;
    tv = (i * 65536 + st / 2) / st;
    v.in_range = 1'b1;
    v.pos_x    = round_q14(sp * cth, 46);
    v.pos_y    = round_q14(cp, 16);
    v.pos_z    = round_q14(sp * sth, 46);
    v.tex_u    = tu[16:0];
    v.tex_v    = tv[16:0];
    if (i < st && j < sl) begin
      tl = i * (sl + 1) + j;
      bl = (i + 1) * (sl + 1) + j;
      v.has_quad     = 1'b1;
      v.top_left     = tl[15:0];
      v.top_right    = 16'(tl + 1);
      v.bottom_left  = bl[15:0];
      v.bottom_right = 16'(bl + 1);
    end
    return v;
  endfunction

  assign vertices_pending = vertex_q.size();

  always @(posedge clk) begin
    vertex_t exp_v;
    vertex_t act_v;
    if (!rst_n) begin
      stack_reg  <= 8'd16;
      slice_reg  <= 8'd32;
      fail_count <= 0;
      vertex_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == uvs_pkg::REG_STACK_COUNT) stack_reg <= cfg_data;
        else if (cfg_index == uvs_pkg::REG_SLICE_COUNT) slice_reg <= cfg_data;
      end
      if (in_valid && in_ready)
        vertex_q = {vertex_q, predict_vertex(in_row, in_column)};
      if (out_valid && out_ready) begin
        act_v = '{out_in_range, out_pos_x, out_pos_y, out_pos_z, out_tex_u,
                  out_tex_v, out_has_quad, out_top_left, out_top_right,
                  out_bottom_left, out_bottom_right};
        if (vertex_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result %h", act_v);
          fail_count <= fail_count + 1;
        end else begin
          exp_v = vertex_q.pop_front();
          if (exp_v !== act_v) begin
            if (fail_count < 10)
              $display("mismatch: expected %h actual %h", exp_v, act_v);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> verif/tb_indexed_uv_sphere_vertex_generator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_uv_sphere_vertex_generator_top
// bursty grid point requests and band count writes against a stalling sink
// ----------------------------------------------------------------------------
module tb_indexed_uv_sphere_vertex_generator_top;

  localparam logic [1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [1:0] REG_UNUSED_3 = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_row;
  logic [7:0]  in_column;
  logic        out_valid;
  logic        out_ready;
  logic        out_in_range;
  logic [15:0] out_pos_x;
  logic [15:0] out_pos_y;
  logic [15:0] out_pos_z;
  logic [16:0] out_tex_u;
  logic [16:0] out_tex_v;
  logic        out_has_quad;
  logic [15:0] out_top_left;
  logic [15:0] out_top_right;
  logic [15:0] out_bottom_left;
  logic [15:0] out_bottom_right;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  int          fail_count;
  int          vertices_pending;
  bit          long_hold;
  int          cur_stacks;
  int          cur_slices;

  indexed_uv_sphere_vertex_generator_top u_top (.*);
  uvs_vertex_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int mode;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      if (($urandom % 64) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 9) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
      @(posedge clk);
    end
  end

  task automatic send_point(input logic [7:0] row, input logic [7:0] column);
    in_valid  <= 1'b1;
    in_row    <= row;
    in_column <= column;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_vertices();
    in_valid <= 1'b0;
    @(posedge clk);
    while (vertices_pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == uvs_pkg::REG_STACK_COUNT) cur_stacks = (data == 0) ? 1 : data;
    if (idx == uvs_pkg::REG_SLICE_COUNT) cur_slices = (data == 0) ? 1 : data;
  endtask

  task automatic random_points(input int count, input bit hold);
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (hold && n == count / 3) long_hold = 1'b1;
      if ($urandom_range(0, 7) == 0)
        send_point(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else
        send_point(8'($urandom_range(0, cur_stacks + 1)),
                   8'($urandom_range(0, cur_slices + 1)));
      if (burst > 0) begin
        burst--;
      end else begin
        burst = $urandom_range(0, 20);
        if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 8));
      end
    end
  endtask

  initial begin
    in_valid   <= 1'b0;
    in_row     <= '0;
    in_column  <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    rst_n      <= 1'b0;
    long_hold  = 1'b0;
    cur_stacks = 16;
    cur_slices = 32;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_point(0, 0);
    send_point(16, 32);
    send_point(15, 31);
    send_point(8, 16);
    send_point(16, 0);
    send_point(0, 32);
    send_point(17, 0);
    send_point(0, 33);
    send_point(255, 255);
    send_point(4, 8);
    random_points(70, 1'b1);
    drain_vertices();

    write_reg(uvs_pkg::REG_STACK_COUNT, 8'd1);
    write_reg(uvs_pkg::REG_SLICE_COUNT, 8'd1);
    send_point(0, 0);
    send_point(1, 1);
    send_point(1, 0);
    send_point(2, 1);
    random_points(40, 1'b0);
    drain_vertices();

    write_reg(uvs_pkg::REG_STACK_COUNT, 8'd255);
    write_reg(uvs_pkg::REG_SLICE_COUNT, 8'd255);
    send_point(254, 254);
    send_point(255, 255);
    send_point(128, 64);
    random_points(80, 1'b0);
    drain_vertices();

    write_reg(uvs_pkg::REG_STACK_COUNT, 8'd0);
    write_reg(uvs_pkg::REG_SLICE_COUNT, 8'd0);
    write_reg(REG_UNUSED_2, 8'd7);
    write_reg(REG_UNUSED_3, 8'd200);
    send_point(0, 0);
    send_point(1, 1);
    send_point(2, 0);
    random_points(40, 1'b0);
    drain_vertices();

    write_reg(uvs_pkg::REG_STACK_COUNT, 8'd255);
    write_reg(uvs_pkg::REG_SLICE_COUNT, 8'd1);
    random_points(70, 1'b1);
    drain_vertices();

    write_reg(uvs_pkg::REG_STACK_COUNT, 8'd3);
    write_reg(uvs_pkg::REG_SLICE_COUNT, 8'd7);
    random_points(80, 1'b0);
    drain_vertices();

    for (int p = 0; p < 4; p++) begin
      write_reg(uvs_pkg::REG_STACK_COUNT, 8'($urandom_range(0, 255)));
      write_reg(uvs_pkg::REG_SLICE_COUNT, 8'($urandom_range(0, 255)));
      random_points(50, 1'b0);
      drain_vertices();
    end

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
